### src/erc_pkg.sv
// erc_pkg: types, codes and helper functions for the elevator round-trip controller
// used by every module of the block; depends on nothing
`default_nettype none

package erc_pkg;

  localparam int QUEUE_DEPTH = 8;
  localparam int NUM_FLOORS  = 8;

  localparam int FLOOR_W  = 4;
  localparam int POS_W    = 6;
  localparam int DWELL_W  = 4;
  localparam int STATUS_W = 3;
  localparam int CNT_W    = $clog2(QUEUE_DEPTH + 1);
  localparam int PTR_W    = $clog2(QUEUE_DEPTH);

  localparam logic [DWELL_W-1:0] DWELL_RESET = DWELL_W'(3);

  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_GROUND = 2'd1;
  localparam logic [1:0] OP_UPPER  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_QUEUED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DUP    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BAD    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_TICK   = 3'd4;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_UP    = 2'd1,
    PH_DOWN  = 2'd2,
    PH_DWELL = 2'd3
  } phase_t;

  typedef struct packed {
    logic [1:0]         op;
    logic [FLOOR_W-1:0] request_floor;
  } in_item_t;

  typedef struct packed {
    logic [FLOOR_W-1:0]  floor_indicator;
    logic [POS_W-1:0]    height_half_m;
    logic [1:0]          motion;
    logic [STATUS_W-1:0] request_status;
    logic [CNT_W-1:0]    ground_pending;
    logic [CNT_W-1:0]    upper_pending;
  } out_item_t;

  typedef struct packed {
    logic               rd_en;
    logic [PTR_W-1:0]   rd_idx;
    logic               wr_en;
    logic [FLOOR_W-1:0] wr_data;
    logic               pop;
  } fifo_cmd_t;

  typedef struct packed {
    logic               start;
    logic               g_avail;
    logic               u_avail;
    logic [FLOOR_W-1:0] g_head;
    logic [FLOOR_W-1:0] u_head;
  } car_ctrl_t;

  typedef struct packed {
    logic done;
    logic pop_g;
    logic pop_u;
  } car_stat_t;

  // 6 * (f - 1) half-metre steps
  function automatic logic [POS_W-1:0] trip_len(input logic [FLOOR_W-1:0] f);
    logic [POS_W-1:0] m;
    m = POS_W'(f - FLOOR_W'(1));
    return (m << 2) + (m << 1);
  endfunction

  // indicator after moving to p: p/6+1 when (p/2) is a multiple of 3
  function automatic logic [FLOOR_W-1:0] show_update(input logic [POS_W-1:0] p,
                                                     input logic [FLOOR_W-1:0] shown);
    logic [POS_W+5:0] prod;
    logic [POS_W-1:0] q;
    logic [POS_W-1:0] r;
    prod = (POS_W+6)'(p) * (POS_W+6)'(43);
    q    = POS_W'(prod >> 8);
    r    = p - ((q << 2) + (q << 1));
    if (r < POS_W'(2)) begin
      return FLOOR_W'(q + POS_W'(1));
    end
    return shown;
  endfunction

  // (a + b) wrapped into the queue depth
  function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] a,
                                                input logic [CNT_W-1:0] b);
    logic [CNT_W+1:0] s;
    s = (CNT_W+2)'(a) + (CNT_W+2)'(b);
    if (s >= (CNT_W+2)'(QUEUE_DEPTH)) begin
      s = s - (CNT_W+2)'(QUEUE_DEPTH);
    end
    return s[PTR_W-1:0];
  endfunction

endpackage

`default_nettype wire

### src/elevator_round_trip_controller.sv
// elevator_round_trip_controller: top level, transaction sequencer, queues and car engine
// depends on erc_pkg, erc_fifo, erc_car
`default_nettype none

// One transaction in, one result out, one transaction at a time. A floor request
// is checked against the queue one stored entry at a time, each entry read in
// S_SCAN and compared in S_CMP; the scan stops early when a duplicate turns up.
// An invalid floor or op goes straight to S_DONE without a scan. A one-second
// tick runs the car engine one step per cycle; when its result is registered is
// set by how many phase changes it walks through. The longest case is when
// floor-1 trips and a zero dwell chain together. The block returns to idle as the
// result is registered and can take the next transaction while that result still
// waits on out_ready. A new result that finds the previous one still waiting is
// held back until out_ready. The user must write dwell_ticks through cfg_we/cfg_wdata
// only while the block is idle; the block itself does not enforce it.
module elevator_round_trip_controller import erc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  in_item_t           in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output out_item_t          out_data,
  input  logic               cfg_we,
  input  logic [DWELL_W-1:0] cfg_wdata
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_CMP,
    S_TICK_RD,
    S_TICK_RUN,
    S_DONE
  } state_t;

  state_t              state_r,  state_nxt;
  logic [1:0]          op_r,     op_nxt;
  logic [FLOOR_W-1:0]  floor_r,  floor_nxt;
  logic [CNT_W-1:0]    idx_r,    idx_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  out_item_t           out_r,    out_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [DWELL_W-1:0]  dwell_r;

  fifo_cmd_t          g_cmd, u_cmd, req_cmd;
  logic [FLOOR_W-1:0] g_rd, u_rd, rd_sel;
  logic [CNT_W-1:0]   g_cnt, u_cnt, cnt_sel;
  logic               is_ground;
  car_ctrl_t          car_ctrl;
  car_stat_t          car_stat;
  phase_t             car_phase;
  logic [POS_W-1:0]   car_pos;
  logic [FLOOR_W-1:0] car_shown;

  erc_fifo u_ground (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (g_cmd),
    .rd_data (g_rd),
    .count   (g_cnt)
  );

  erc_fifo u_upper (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (u_cmd),
    .rd_data (u_rd),
    .count   (u_cnt)
  );

  erc_car u_car (
    .clk         (clk),
    .rst_n       (rst_n),
    .dwell_ticks (dwell_r),
    .ctrl        (car_ctrl),
    .stat        (car_stat),
    .phase       (car_phase),
    .position    (car_pos),
    .shown_floor (car_shown)
  );

  assign is_ground = (op_r == OP_GROUND);
  assign cnt_sel   = is_ground ? g_cnt : u_cnt;
  assign rd_sel    = is_ground ? g_rd : u_rd;

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    floor_nxt     = floor_r;
    idx_nxt       = idx_r;
    status_nxt    = status_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    in_ready      = 1'b0;
    req_cmd       = '0;
    car_ctrl      = '0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op_nxt    = in_data.op;
          floor_nxt = in_data.request_floor;
          idx_nxt   = '0;
          priority if (in_data.op == OP_TICK) begin
            state_nxt = S_TICK_RD;
          end else if ((in_data.op == OP_GROUND || in_data.op == OP_UPPER) &&
                       in_data.request_floor != '0 &&
                       in_data.request_floor <= FLOOR_W'(NUM_FLOORS)) begin
            state_nxt = S_SCAN;
          end else begin
            status_nxt = ST_BAD;
            state_nxt  = S_DONE;
          end
        end
      end
      S_SCAN: begin
        if (idx_r < cnt_sel) begin
          req_cmd.rd_en  = 1'b1;
          req_cmd.rd_idx = idx_r[PTR_W-1:0];
          state_nxt      = S_CMP;
        end else if (cnt_sel >= CNT_W'(QUEUE_DEPTH)) begin
          status_nxt = ST_FULL;
          state_nxt  = S_DONE;
        end else begin
          req_cmd.wr_en   = 1'b1;
          req_cmd.wr_data = floor_r;
          status_nxt      = ST_QUEUED;
          state_nxt       = S_DONE;
        end
      end
      S_CMP: begin
        if (rd_sel == floor_r) begin
          status_nxt = ST_DUP;
          state_nxt  = S_DONE;
        end else begin
          idx_nxt   = idx_r + CNT_W'(1);
          state_nxt = S_SCAN;
        end
      end
      S_TICK_RD: begin
        car_ctrl.start = 1'b1;
        state_nxt      = S_TICK_RUN;
      end
      S_TICK_RUN: begin
        if (car_stat.done) begin
          status_nxt = ST_TICK;
          state_nxt  = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_nxt.floor_indicator = car_shown;
          out_nxt.height_half_m   = car_pos;
          out_nxt.motion          = car_phase;
          out_nxt.request_status  = status_r;
          out_nxt.ground_pending  = g_cnt;
          out_nxt.upper_pending   = u_cnt;
          out_valid_nxt           = 1'b1;
          state_nxt               = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    car_ctrl.g_avail = (g_cnt != '0);
    car_ctrl.u_avail = (u_cnt != '0);
    car_ctrl.g_head  = g_rd;
    car_ctrl.u_head  = u_rd;
  end

  // head reads for a tick go to both queues, request traffic to the selected one
  always_comb begin
    g_cmd = '0;
    u_cmd = '0;
    if (state_r == S_TICK_RD) begin
      g_cmd.rd_en = 1'b1;
      u_cmd.rd_en = 1'b1;
    end else if (is_ground) begin
      g_cmd = req_cmd;
    end else begin
      u_cmd = req_cmd;
    end
    g_cmd.pop = car_stat.pop_g;
    u_cmd.pop = car_stat.pop_u;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      dwell_r     <= DWELL_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        dwell_r <= cfg_wdata;
      end
    end
    op_r     <= op_nxt;
    floor_r  <= floor_nxt;
    idx_r    <= idx_nxt;
    status_r <= status_nxt;
    out_r    <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

### src/erc_fifo.sv
// erc_fifo: one landing request queue, circular store with registered read port
// depends on erc_pkg
`default_nettype none

module erc_fifo import erc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  fifo_cmd_t          cmd,
  output logic [FLOOR_W-1:0] rd_data,
  output logic [CNT_W-1:0]   count
);

  logic [FLOOR_W-1:0] mem [QUEUE_DEPTH];
  logic [FLOOR_W-1:0] rd_data_r;
  logic [PTR_W-1:0]   head_r;
  logic [CNT_W-1:0]   count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else if (cmd.wr_en) begin
      count_r <= count_r + CNT_W'(1);
    end else if (cmd.pop) begin
      head_r  <= wrap_add(head_r, CNT_W'(1));
      count_r <= count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wrap_add(head_r, count_r)] <= cmd.wr_data;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[wrap_add(head_r, CNT_W'(cmd.rd_idx))];
    end
  end

  assign rd_data = rd_data_r;
  assign count   = count_r;

endmodule

`default_nettype wire

### src/erc_car.sv
// erc_car: car motion engine, one step of the tick sequence per cycle
// depends on erc_pkg
`default_nettype none

module erc_car import erc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [DWELL_W-1:0] dwell_ticks,
  input  car_ctrl_t          ctrl,
  output car_stat_t          stat,
  output phase_t             phase,
  output logic [POS_W-1:0]   position,
  output logic [FLOOR_W-1:0] shown_floor
);

  logic               busy_r,   busy_nxt;
  logic               popped_r, popped_nxt;
  phase_t             phase_r,  phase_nxt;
  logic [POS_W-1:0]   pos_r,    pos_nxt;
  logic [POS_W-1:0]   steps_r,  steps_nxt;
  logic [POS_W-1:0]   len_r,    len_nxt;
  logic [DWELL_W-1:0] dwell_r,  dwell_nxt;
  logic [FLOOR_W-1:0] shown_r,  shown_nxt;
  logic [FLOOR_W-1:0] held_r,   held_nxt;
  logic [POS_W-1:0]   p;

  always_comb begin
    busy_nxt   = busy_r;
    popped_nxt = popped_r;
    phase_nxt  = phase_r;
    pos_nxt    = pos_r;
    steps_nxt  = steps_r;
    len_nxt    = len_r;
    dwell_nxt  = dwell_r;
    shown_nxt  = shown_r;
    held_nxt   = held_r;
    stat       = '0;
    p          = '0;
    if (busy_r) begin
      unique case (phase_r)
        PH_IDLE: begin
          if (held_r != '0) begin
            len_nxt   = trip_len(held_r);
            steps_nxt = trip_len(held_r);
            phase_nxt = PH_UP;
            held_nxt  = '0;
          end else if (!popped_r && (ctrl.g_avail || ctrl.u_avail)) begin
            popped_nxt = 1'b1;
            stat.pop_g = ctrl.g_avail;
            stat.pop_u = ctrl.u_avail;
            phase_nxt  = PH_UP;
            if (ctrl.g_avail) begin
              len_nxt   = trip_len(ctrl.g_head);
              steps_nxt = trip_len(ctrl.g_head);
              held_nxt  = ctrl.u_avail ? ctrl.u_head : '0;
            end else begin
              len_nxt   = trip_len(ctrl.u_head);
              steps_nxt = trip_len(ctrl.u_head);
            end
          end else begin
            stat.done = 1'b1;
          end
        end
        PH_UP: begin
          if (steps_r != '0) begin
            p         = len_r - steps_r + POS_W'(1);
            pos_nxt   = p;
            shown_nxt = show_update(p, shown_r);
            steps_nxt = steps_r - POS_W'(1);
            stat.done = 1'b1;
          end else begin
            phase_nxt = PH_DOWN;
            steps_nxt = len_r;
          end
        end
        PH_DOWN: begin
          if (steps_r != '0) begin
            p         = steps_r;
            steps_nxt = steps_r - POS_W'(1);
            stat.done = 1'b1;
          end else begin
            p         = '0;
            phase_nxt = PH_DWELL;
            dwell_nxt = dwell_ticks;
          end
          pos_nxt   = p;
          shown_nxt = show_update(p, shown_r);
        end
        PH_DWELL: begin
          if (dwell_r != '0) begin
            dwell_nxt = dwell_r - DWELL_W'(1);
            stat.done = 1'b1;
          end else begin
            phase_nxt = PH_IDLE;
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
      busy_nxt = !stat.done;
    end else if (ctrl.start) begin
      busy_nxt   = 1'b1;
      popped_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      popped_r <= 1'b0;
      phase_r  <= PH_IDLE;
      pos_r    <= '0;
      steps_r  <= '0;
      len_r    <= '0;
      dwell_r  <= '0;
      shown_r  <= FLOOR_W'(1);
      held_r   <= '0;
    end else begin
      busy_r   <= busy_nxt;
      popped_r <= popped_nxt;
      phase_r  <= phase_nxt;
      pos_r    <= pos_nxt;
      steps_r  <= steps_nxt;
      len_r    <= len_nxt;
      dwell_r  <= dwell_nxt;
      shown_r  <= shown_nxt;
      held_r   <= held_nxt;
    end
  end

  assign phase       = phase_r;
  assign position    = pos_r;
  assign shown_floor = shown_r;

endmodule

`default_nettype wire

### src/erc_checker.sv
// erc_checker: port-level assertions for the elevator round-trip controller
// depends on erc_pkg; bound to elevator_round_trip_controller
`default_nettype none

module erc_checker import erc_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input out_item_t          out_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // one transaction at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted a transaction while busy");

  a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.ground_pending <= CNT_W'(QUEUE_DEPTH) &&
                  out_data.upper_pending <= CNT_W'(QUEUE_DEPTH))
    else $error("pending count beyond queue depth");

  // car rests at ground when idle or dwelling
  a_rest_at_ground: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.motion == PH_IDLE || out_data.motion == PH_DWELL)
      |-> out_data.height_half_m == '0)
    else $error("car off ground while idle or dwelling");

  a_ground_indicator: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.height_half_m == '0 |-> out_data.floor_indicator == FLOOR_W'(1))
    else $error("indicator wrong at ground");

endmodule

bind elevator_round_trip_controller erc_checker u_erc_checker (.*);

`default_nettype wire
